// ----- sv/msec_pkg.sv -----
package msec_pkg;

  localparam int unsigned IDX_W   = 5;
  localparam int unsigned IMM_W   = 16;
  localparam int unsigned DATA_W  = 32;
  localparam int unsigned KIND_W  = 4;
  localparam int unsigned OPC_W   = 16;
  localparam int unsigned MADDR_W = 6;
  localparam int unsigned IN_W    = 32;
  localparam int unsigned OUT_W   = 64;

  typedef enum logic [KIND_W-1:0] {
    OP_ADD  = 4'd0,
    OP_ADDI = 4'd1,
    OP_SUB  = 4'd2,
    OP_MUL  = 4'd3,
    OP_BEQ  = 4'd4,
    OP_LW   = 4'd5,
    OP_SW   = 4'd6,
    OP_HALT = 4'd7,
    OP_NOP  = 4'd8
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [IDX_W-1:0] rs;
    logic             rs_ok;
    logic [IDX_W-1:0] rt;
    logic             rt_ok;
    logic [IDX_W-1:0] dst;
    logic             dst_ok;
    logic [IMM_W-1:0] imm;
  } dec_t;

  // packed from next_pc (lsb) up to halted (msb)
  typedef struct packed {
    logic               halted;
    logic               address_error;
    logic               branch_taken;
    logic [MADDR_W-1:0] mem_address;
    logic               mem_written;
    logic [DATA_W-1:0]  written_value;
    logic [IDX_W-1:0]   written_reg;
    logic               reg_written;
    logic [OPC_W-1:0]   next_pc;
  } res_t;

endpackage

// ----- sv/mips_subset_execute_core.sv -----
// Execute core for a small MIPS-like instruction subset.
// Input stream (s_axis): one decoded instruction per transaction; tuser carries
// the opcode, tdata the register indexes and the 16-bit immediate.
// Output stream (m_axis): one result per instruction, in order, with the new
// PC, register or memory write, and branch / address error / halted flags.
// Throughput is set by the register file read, execute and write-back loop:
// a new instruction is read only after the one before it leaves execute
// (write-back shares a cycle with the next read).
// A 2-entry queue sits between decode and execute, and the result sits in an
// output register, so new instructions are taken while a result waits.
// When m_axis_tready is low, the result holds, execute stops, and the queue
// fills before s_axis_tready drops.
// Reset: register file and data memory are zeroed by a sweep over
// max(REG_COUNT, MEM_WORDS) addresses; s_axis_tready stays low
// during the sweep. PC and halt flag clear at once.
// After halt, instructions return the unchanged PC with halted set.
module mips_subset_execute_core #(
  parameter int REG_COUNT = 32,
  parameter int MEM_WORDS = 64,
  parameter int PC_BITS   = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // src_reg[4:0], tgt_reg[9:5], dst_reg[14:10], imm[30:15], zero[31]
  input  logic [31:0] s_axis_tdata,
  // kind[3:0]
  input  logic [3:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // next_pc[15:0], reg_written[16], written_reg[21:17], written_value[53:22],
  // mem_written[54], mem_address[60:55], branch_taken[61], address_error[62],
  // halted[63]
  output logic [63:0] m_axis_tdata
);

  logic           push, pop, q_full, q_vld, clr_busy;
  msec_pkg::dec_t dec, q_data;
  msec_pkg::res_t res;

  msec_front #(
    .REG_COUNT(REG_COUNT)
  ) u_front (
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_data_i  (s_axis_tdata),
    .in_user_i  (s_axis_tuser),
    .q_full_i   (q_full),
    .clr_busy_i (clr_busy),
    .push_o     (push),
    .dec_o      (dec)
  );

  msec_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (dec),
    .pop_i       (pop),
    .full_o      (q_full),
    .vld_o       (q_vld),
    .pop_data_o  (q_data)
  );

  msec_back #(
    .REG_COUNT(REG_COUNT),
    .MEM_WORDS(MEM_WORDS),
    .PC_BITS  (PC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_vld_i     (q_vld),
    .q_data_i    (q_data),
    .q_pop_o     (pop),
    .clr_busy_o  (clr_busy),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (res)
  );

  assign m_axis_tdata = res;

endmodule

// ----- sv/msec_front.sv -----
module msec_front #(
  parameter int REG_COUNT = 32
) (
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [msec_pkg::IN_W-1:0]           in_data_i,
  input  logic [msec_pkg::KIND_W-1:0]         in_user_i,
  input  logic                                q_full_i,
  input  logic                                clr_busy_i,
  output logic                                push_o,
  output msec_pkg::dec_t                      dec_o
);

  logic [msec_pkg::IDX_W-1:0] rs, rt, rd;

  function automatic logic reg_ok(input logic [msec_pkg::IDX_W-1:0] idx);
    reg_ok = (idx != '0) && (int'(idx) < REG_COUNT);
  endfunction

  assign rs = in_data_i[4:0];
  assign rt = in_data_i[9:5];
  assign rd = in_data_i[14:10];

  always_comb begin
    dec_o        = '0;
    dec_o.op     = (in_user_i <= msec_pkg::OP_HALT) ? msec_pkg::op_e'(in_user_i)
                                                    : msec_pkg::OP_NOP;
    dec_o.rs     = rs;
    dec_o.rs_ok  = reg_ok(rs);
    dec_o.rt     = rt;
    dec_o.rt_ok  = reg_ok(rt);
    dec_o.imm    = in_data_i[30:15];
    unique case (dec_o.op) inside
      msec_pkg::OP_ADD, msec_pkg::OP_SUB, msec_pkg::OP_MUL: begin
        dec_o.dst    = rd;
        dec_o.dst_ok = reg_ok(rd);
      end
      msec_pkg::OP_ADDI, msec_pkg::OP_LW: begin
        dec_o.dst    = rt;
        dec_o.dst_ok = reg_ok(rt);
      end
      default: begin
        dec_o.dst    = '0;
        dec_o.dst_ok = 1'b0;
      end
    endcase
  end

  assign in_ready_o = !q_full_i && !clr_busy_i;
  assign push_o     = in_valid_i && in_ready_o;

endmodule

// ----- sv/msec_fifo.sv -----
module msec_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  msec_pkg::dec_t push_data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           vld_o,
  output msec_pkg::dec_t pop_data_o
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  msec_pkg::dec_t  buf_q [DEPTH];
  logic [PW-1:0]   wp_q, wp_d, rp_q, rp_d;
  logic [PW:0]     cnt_q, cnt_d;

  assign full_o     = (cnt_q == (PW+1)'(DEPTH));
  assign vld_o      = (cnt_q != '0);
  assign pop_data_o = buf_q[rp_q];

  always_comb begin
    wp_d  = push_i ? wp_q + 1'b1 : wp_q;
    rp_d  = pop_i  ? rp_q + 1'b1 : rp_q;
    cnt_d = cnt_q + (PW+1)'(push_i) - (PW+1)'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      wp_q  <= wp_d;
      rp_q  <= rp_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      buf_q[wp_q] <= push_data_i;
    end
  end

endmodule

// ----- sv/msec_back.sv -----
module msec_back #(
  parameter int REG_COUNT = 32,
  parameter int MEM_WORDS = 64,
  parameter int PC_BITS   = 16
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_vld_i,
  input  msec_pkg::dec_t q_data_i,
  output logic           q_pop_o,
  output logic           clr_busy_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output msec_pkg::res_t out_data_o
);

  localparam int RW     = $clog2(REG_COUNT);
  localparam int AW     = $clog2(MEM_WORDS);
  localparam int CLR_N  = (REG_COUNT > MEM_WORDS) ? REG_COUNT : MEM_WORDS;
  localparam int CW     = $clog2(CLR_N) + 1;
  localparam int ADDR_W = msec_pkg::DATA_W + 2;

  logic [msec_pkg::DATA_W-1:0] rf [REG_COUNT];
  logic [msec_pkg::DATA_W-1:0] dmem [MEM_WORDS];

  logic [CW-1:0]               clr_q;
  logic                        ex_vld_q, wb_vld_q, out_vld_q;
  msec_pkg::dec_t              ex_q;
  msec_pkg::res_t              wb_q, wb_d, wb_res, out_q;
  logic                        wb_lw_q, wb_lw_d;
  logic [msec_pkg::DATA_W-1:0] rda_q, rdb_q, mrd_q;
  logic [PC_BITS-1:0]          pc_q, pc_d;
  logic                        halt_q;

  logic                        issue, ex_adv, wb_done, rf_we;
  logic [msec_pkg::DATA_W-1:0] a, b, alu, wb_val;
  logic [ADDR_W-1:0]           addr;
  logic                        in_range, mem_we, mem_re;
  logic [AW-1:0]               mem_idx;
  logic [RW-1:0]               wa, ra, rb;

  assign clr_busy_o = (clr_q < CW'(CLR_N));
  assign wb_done    = wb_vld_q && (!out_vld_q || out_ready_i);
  assign ex_adv     = ex_vld_q && (!wb_vld_q || wb_done);
  assign issue      = q_vld_i && !clr_busy_o && !ex_vld_q && (!wb_vld_q || wb_done);
  assign q_pop_o    = issue;

  // execute
  assign a        = ex_q.rs_ok ? rda_q : '0;
  assign b        = ex_q.rt_ok ? rdb_q : '0;
  assign addr     = {{2{a[msec_pkg::DATA_W-1]}}, a}
                  + ADDR_W'(ex_q.imm);
  assign in_range = !addr[ADDR_W-1] && (addr < ADDR_W'(MEM_WORDS));
  assign mem_idx  = addr[AW-1:0];

  always_comb begin
    unique case (ex_q.op)
      msec_pkg::OP_ADD:  alu = a + b;
      msec_pkg::OP_ADDI: alu = a + msec_pkg::DATA_W'(ex_q.imm);
      msec_pkg::OP_SUB:  alu = a - b;
      msec_pkg::OP_MUL:  alu = a * b;
      default:           alu = '0;
    endcase
  end

  always_comb begin
    wb_d    = '0;
    wb_lw_d = 1'b0;
    pc_d    = pc_q + PC_BITS'(1);
    if (halt_q) begin
      pc_d        = pc_q;
      wb_d.halted = 1'b1;
    end else begin
      unique case (ex_q.op) inside
        msec_pkg::OP_ADD, msec_pkg::OP_ADDI, msec_pkg::OP_SUB, msec_pkg::OP_MUL: begin
          wb_d.reg_written   = ex_q.dst_ok;
          wb_d.written_reg   = ex_q.dst_ok ? ex_q.dst : '0;
          wb_d.written_value = ex_q.dst_ok ? alu : '0;
        end
        msec_pkg::OP_BEQ: begin
          if (a == b) begin
            wb_d.branch_taken = 1'b1;
            pc_d              = pc_q + PC_BITS'(ex_q.imm);
          end
        end
        msec_pkg::OP_LW, msec_pkg::OP_SW: begin
          if (!in_range) begin
            wb_d.address_error = 1'b1;
          end else begin
            wb_d.mem_address = addr[msec_pkg::MADDR_W-1:0];
            if (ex_q.op == msec_pkg::OP_SW) begin
              wb_d.mem_written   = 1'b1;
              wb_d.written_value = b;
            end else begin
              wb_d.reg_written = ex_q.dst_ok;
              wb_d.written_reg = ex_q.dst_ok ? ex_q.dst : '0;
              wb_lw_d          = ex_q.dst_ok;
            end
          end
        end
        msec_pkg::OP_HALT: wb_d.halted = 1'b1;
        default: ;
      endcase
    end
    wb_d.next_pc = msec_pkg::OPC_W'(pc_d);
  end

  assign mem_we = ex_adv && !halt_q && in_range && (ex_q.op == msec_pkg::OP_SW);
  assign mem_re = ex_adv && !halt_q && in_range && (ex_q.op == msec_pkg::OP_LW);

  // write back
  assign wb_val = wb_lw_q ? mrd_q : wb_q.written_value;
  assign rf_we  = wb_done && wb_q.reg_written;
  assign wa     = wb_q.written_reg[RW-1:0];
  assign ra     = q_data_i.rs[RW-1:0];
  assign rb     = q_data_i.rt[RW-1:0];

  always_comb begin
    wb_res               = wb_q;
    wb_res.written_value = wb_val;
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      if (clr_q < CW'(REG_COUNT)) begin
        rf[clr_q[RW-1:0]] <= '0;
      end
    end else if (rf_we) begin
      rf[wa] <= wb_val;
    end
    if (issue) begin
      rda_q <= (rf_we && wa == ra) ? wb_val : rf[ra];
      rdb_q <= (rf_we && wa == rb) ? wb_val : rf[rb];
    end
  end

  always_ff @(posedge clk_i) begin
    if (clr_busy_o) begin
      if (clr_q < CW'(MEM_WORDS)) begin
        dmem[clr_q[AW-1:0]] <= '0;
      end
    end else if (mem_we) begin
      dmem[mem_idx] <= b;
    end
    if (mem_re) begin
      mrd_q <= dmem[mem_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q     <= '0;
      ex_vld_q  <= 1'b0;
      wb_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      pc_q      <= '0;
      halt_q    <= 1'b0;
    end else begin
      if (clr_busy_o) begin
        clr_q <= clr_q + CW'(1);
      end
      if (issue) begin
        ex_vld_q <= 1'b1;
      end else if (ex_adv) begin
        ex_vld_q <= 1'b0;
      end
      if (ex_adv) begin
        wb_vld_q <= 1'b1;
        pc_q     <= pc_d;
        if (ex_q.op == msec_pkg::OP_HALT) begin
          halt_q <= 1'b1;
        end
      end else if (wb_done) begin
        wb_vld_q <= 1'b0;
      end
      if (wb_done) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      ex_q <= q_data_i;
    end
    if (ex_adv) begin
      wb_q    <= wb_d;
      wb_lw_q <= wb_lw_d;
    end
    if (wb_done) begin
      out_q <= wb_res;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

endmodule

// ----- sv/msec_checker.sv -----
module msec_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [63:0] m_axis_tdata
);

  msec_pkg::res_t res;

  assign res = m_axis_tdata;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_clear_sweep: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rst_ni) |-> !s_axis_tready)
    else $error("input taken during memory clear");

  a_addr_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.address_error |->
      !res.reg_written && !res.mem_written && res.mem_address == '0)
    else $error("access made despite address error");

  a_no_r0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.reg_written |-> res.written_reg != '0 && !res.mem_written)
    else $error("bad register write report");

  a_halted_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && res.halted |->
      !res.reg_written && !res.mem_written && !res.branch_taken && !res.address_error)
    else $error("halted result shows activity");

endmodule

bind mips_subset_execute_core msec_checker u_chk (.*);

// ----- bench/tb_mips_subset_execute_core.sv -----
module tb_mips_subset_execute_core;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int REG_DEPTH = 32;
  localparam int MEM_DEPTH = 64;
  localparam int RANDOM_ITEMS = 500;
  localparam int CALM_FROM = 400;
  localparam int POST_HALT_ITEMS = 10;
  localparam logic [msec_pkg::KIND_W-1:0] KIND_UNDEF_LO = 4'h9;
  localparam logic [msec_pkg::KIND_W-1:0] KIND_UNDEF_HI = 4'hF;

  typedef struct {
    logic [msec_pkg::KIND_W-1:0] kind;
    logic [msec_pkg::IDX_W-1:0]  rs;
    logic [msec_pkg::IDX_W-1:0]  rt;
    logic [msec_pkg::IDX_W-1:0]  rd;
    logic [msec_pkg::IMM_W-1:0]  imm;
    logic                        typed;
    msec_pkg::res_t              want;
  } instr_t;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [3:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;

  // architectural state mirror
  logic [msec_pkg::DATA_W-1:0] gpr [REG_DEPTH];
  logic [msec_pkg::DATA_W-1:0] dmem [MEM_DEPTH];
  logic [msec_pkg::OPC_W-1:0]  pc_q;
  logic                        halt_q;

  msec_pkg::res_t pending_results [$];
  instr_t         program_rows [$];
  int             mismatches = 0;
  bit             calm = 1'b0;
  bit             src_bursty = 1'b1;
  bit             sink_bursty = 1'b1;

  mips_subset_execute_core u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("mips_subset_execute_core: mismatch");
    $finish;
  end

  function automatic msec_pkg::res_t run_instr(instr_t it);
    msec_pkg::res_t              r;
    logic [msec_pkg::DATA_W-1:0] a;
    logic [msec_pkg::DATA_W-1:0] b;
    logic [msec_pkg::DATA_W-1:0] val;
    logic                        has_dst;
    logic [msec_pkg::IDX_W-1:0]  dst;
    longint                      addr;
    r = '0;
    if (halt_q) begin
      r.next_pc = pc_q;
      r.halted  = 1'b1;
      return r;
    end
    a       = gpr[it.rs];
    b       = gpr[it.rt];
    has_dst = 1'b0;
    dst     = '0;
    val     = '0;
    r.next_pc = pc_q + 16'd1;
    case (it.kind)
      msec_pkg::OP_ADD: begin
        has_dst = 1'b1; dst = it.rd; val = a + b;
      end
      msec_pkg::OP_ADDI: begin
        has_dst = 1'b1; dst = it.rt; val = a + {16'd0, it.imm};
      end
      msec_pkg::OP_SUB: begin
        has_dst = 1'b1; dst = it.rd; val = a - b;
      end
      msec_pkg::OP_MUL: begin
        has_dst = 1'b1; dst = it.rd; val = a * b;
      end
      msec_pkg::OP_BEQ: begin
        if (a == b) begin
          r.branch_taken = 1'b1;
          r.next_pc      = pc_q + it.imm;
        end
      end
      msec_pkg::OP_LW, msec_pkg::OP_SW: begin
        addr = longint'($signed(a)) + longint'(it.imm);
        if (addr < 0 || addr >= MEM_DEPTH) begin
          r.address_error = 1'b1;
        end else begin
          r.mem_address = addr[msec_pkg::MADDR_W-1:0];
          if (it.kind == msec_pkg::OP_LW) begin
            has_dst = 1'b1; dst = it.rt; val = dmem[addr[msec_pkg::MADDR_W-1:0]];
          end else begin
            dmem[addr[msec_pkg::MADDR_W-1:0]] = b;
            r.mem_written   = 1'b1;
            r.written_value = b;
          end
        end
      end
      msec_pkg::OP_HALT: halt_q = 1'b1;
      default: ;
    endcase
    // r0 stays zero: writes to it are dropped
    if (has_dst && dst != '0) begin
      gpr[dst]        = val;
      r.reg_written   = 1'b1;
      r.written_reg   = dst;
      r.written_value = val;
    end
    pc_q     = r.next_pc;
    r.halted = halt_q;
    return r;
  endfunction

  function automatic instr_t row(logic [msec_pkg::KIND_W-1:0] k,
                                 logic [msec_pkg::IDX_W-1:0] s,
                                 logic [msec_pkg::IDX_W-1:0] t,
                                 logic [msec_pkg::IDX_W-1:0] d,
                                 logic [msec_pkg::IMM_W-1:0] im, logic typed,
                                 msec_pkg::res_t want);
    instr_t it;
    it.kind = k; it.rs = s; it.rt = t; it.rd = d; it.imm = im;
    it.typed = typed;
    it.want  = want;
    return it;
  endfunction

  function automatic msec_pkg::res_t typed_result(logic [msec_pkg::OPC_W-1:0] pc,
                                                  logic wr,
                                                  logic [msec_pkg::IDX_W-1:0] wreg,
                                                  logic [msec_pkg::DATA_W-1:0] wval,
                                                  logic aerr);
    msec_pkg::res_t r;
    r = '0;
    r.next_pc       = pc;
    r.reg_written   = wr;
    r.written_reg   = wreg;
    r.written_value = wval;
    r.address_error = aerr;
    return r;
  endfunction

  function automatic instr_t random_instr(bit allow_halt);
    instr_t it;
    int     pick;
    it = row(msec_pkg::OP_NOP, 5'($urandom_range(0, 31)), 5'($urandom_range(0, 31)),
             5'($urandom_range(0, 31)), 16'($urandom_range(0, 65535)), 1'b0, '0);
    pick = $urandom_range(0, 99);
    if (pick < 10)      it.kind = msec_pkg::OP_ADD;
    else if (pick < 20) it.kind = msec_pkg::OP_ADDI;
    else if (pick < 28) it.kind = msec_pkg::OP_SUB;
    else if (pick < 36) it.kind = msec_pkg::OP_MUL;
    else if (pick < 50) it.kind = msec_pkg::OP_BEQ;
    else if (pick < 66) it.kind = msec_pkg::OP_LW;
    else if (pick < 82) it.kind = msec_pkg::OP_SW;
    else if (pick < 90) it.kind = 4'($urandom_range(KIND_UNDEF_LO, KIND_UNDEF_HI));
    else if (pick < 94) it.kind = msec_pkg::OP_NOP;
    else                it.kind = 4'($urandom_range(0, 15));
    if (!allow_halt && it.kind == msec_pkg::OP_HALT) it.kind = msec_pkg::OP_NOP;
    if ((it.kind == msec_pkg::OP_LW || it.kind == msec_pkg::OP_SW) &&
        $urandom_range(0, 9) < 8) begin
      if ($urandom_range(0, 1) == 0) it.rs = '0;
      it.imm = 16'($urandom_range(0, MEM_DEPTH + 3));
    end
    if (it.kind == msec_pkg::OP_BEQ && $urandom_range(0, 1) == 0) it.rt = it.rs;
    if (it.kind == msec_pkg::OP_ADDI && $urandom_range(0, 3) == 0)
      it.imm = 16'($urandom_range(0, 15));
    return it;
  endfunction

  function automatic string show(msec_pkg::res_t r);
    return $sformatf("pc=%h wr=%b reg=%0d val=%h mw=%b ma=%0d bt=%b ae=%b h=%b",
                     r.next_pc, r.reg_written, r.written_reg, r.written_value,
                     r.mem_written, r.mem_address, r.branch_taken,
                     r.address_error, r.halted);
  endfunction

  task automatic log_miss(string msg);
    mismatches++;
    if (mismatches <= 10) $display("%t %s", $realtime, msg);
  endtask

  task automatic issue(instr_t it);
    msec_pkg::res_t predicted;
    if ($urandom_range(0, 31) == 0) src_bursty = !src_bursty;
    if (!calm && src_bursty && $urandom_range(0, 2) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, it.imm, it.rd, it.rt, it.rs};
    s_axis_tuser  <= it.kind;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = run_instr(it);
    pending_results.push_back(it.typed ? it.want : predicted);
  endtask

  // result sink with bursty backpressure
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    m_axis_tready <= 1'b1;
    forever begin
      @(posedge clk_i);
      if ($urandom_range(0, 63) == 0) sink_bursty = !sink_bursty;
      if (!calm && sink_bursty && $urandom_range(0, 11) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    msec_pkg::res_t got;
    msec_pkg::res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = msec_pkg::res_t'(m_axis_tdata);
      if (pending_results.size() == 0) begin
        log_miss({"unexpected transaction: ", show(got)});
      end else begin
        want = pending_results.pop_front();
        if (got !== want)
          log_miss({"exp ", show(want), "\n  got ", show(got)});
      end
    end
  end

  initial begin
    int n_pre;
    for (int i = 0; i < REG_DEPTH; i++) gpr[i] = '0;
    for (int i = 0; i < MEM_DEPTH; i++) dmem[i] = '0;
    pc_q   = '0;
    halt_q = 1'b0;

    // opening rows run from the reset state
    program_rows.push_back(row(msec_pkg::OP_ADD,  0, 0, 1, 16'h0000, 1'b1,
                               typed_result(1, 1'b1, 1, 32'h0, 1'b0)));
    program_rows.push_back(row(msec_pkg::OP_ADDI, 0, 1, 0, 16'hFFFF, 1'b1,
                               typed_result(2, 1'b1, 1, 32'h0000FFFF, 1'b0)));
    program_rows.push_back(row(msec_pkg::OP_ADDI, 1, 31, 0, 16'hFFFF, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_ADDI, 31, 0, 0, 16'd5, 1'b1,
                               typed_result(4, 1'b0, 0, 32'h0, 1'b0)));
    program_rows.push_back(row(msec_pkg::OP_SW,   0, 31, 0, 16'd64, 1'b1,
                               typed_result(5, 1'b0, 0, 32'h0, 1'b1)));
    program_rows.push_back(row(msec_pkg::OP_LW,   1, 7, 0, 16'hFFFF, 1'b1,
                               typed_result(6, 1'b0, 0, 32'h0, 1'b1)));
    program_rows.push_back(row(msec_pkg::OP_SUB,  0, 1, 2, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_MUL,  2, 31, 3, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_ADD,  31, 2, 4, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_SW,   0, 31, 0, 16'd63, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_SW,   0, 2, 0, 16'd0, 1'b0, '0));
    // negative base plus offset lands on word 0, then on -1
    program_rows.push_back(row(msec_pkg::OP_LW,   2, 5, 0, 16'hFFFF, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_LW,   2, 6, 0, 16'hFFFE, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_LW,   0, 0, 0, 16'd63, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_LW,   0, 8, 0, 16'd63, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_BEQ,  0, 0, 0, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_BEQ,  1, 2, 0, 16'd5, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_BEQ,  5, 2, 0, 16'hFFFF, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_MUL,  1, 1, 9, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_ADD,  3, 8, 31, 16'h0, 1'b0, '0));
    program_rows.push_back(row(KIND_UNDEF_HI, 31, 31, 31, 16'hFFFF, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_NOP,  31, 31, 31, 16'hFFFF, 1'b0, '0));
    n_pre = program_rows.size();
    // closing rows: halt, then everything is frozen
    program_rows.push_back(row(msec_pkg::OP_HALT, 0, 0, 0, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_ADD,  31, 31, 1, 16'h0, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_SW,   0, 31, 0, 16'd1, 1'b0, '0));
    program_rows.push_back(row(msec_pkg::OP_HALT, 0, 0, 0, 16'h0, 1'b0, '0));

    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < n_pre; i++) issue(program_rows[i]);
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == CALM_FROM) calm = 1'b1;
      issue(random_instr(1'b0));
    end
    for (int i = n_pre; i < program_rows.size(); i++) issue(program_rows[i]);
    for (int i = 0; i < POST_HALT_ITEMS; i++) issue(random_instr(1'b1));
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("mips_subset_execute_core: match");
    end else begin
      $display("mips_subset_execute_core: mismatch");
    end
    $finish;
  end

endmodule
